[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on clk_i, switched off while reset is held.
`define QHD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion clocked on clk_i that is also checked during reset.
`define QHD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/qhd_pkg.sv]
// Types, constants and helper functions of the quoted hex string decoder.
`default_nettype none
package qhd_pkg;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [3:0] HEX_TEN    = 4'd10;

  localparam logic [7:0] MAX_BYTES_RESET = 8'd128;
  localparam logic [8:0] DIGIT_POS_MAX   = 9'd511;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_OPEN = 2'b10
  } phase_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic       last;
  } result_t;

  // Bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      r = {1'b1, 4'(c - CHAR_0)};
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      r = {1'b1, 4'(c - CHAR_UA) + HEX_TEN};
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      r = {1'b1, 4'(c - CHAR_LA) + HEX_TEN};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[design/qhd_ifs.sv]
// Valid/ready channel interfaces for characters in and results out.
`default_nettype none
interface qhd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       field_start;
  logic       text_end;

  modport source (output valid, output character, output field_start, output text_end,
                  input ready);
  modport sink (input valid, input character, input field_start, input text_end,
                output ready);
endinterface

interface qhd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic       last_of_run;

  modport source (output valid, output kind, output value, output last_of_run,
                  input ready);
  modport sink (input valid, input kind, input value, input last_of_run,
                output ready);
endinterface
`default_nettype wire

[design/quoted_hex_string_decoder.sv]
// Top level of the quoted hex string decoder.
//
// Characters of a command parameter arrive one per beat on in_s, with
// field_start marking the opening quote of a field and text_end the last
// character of the text. Results leave on out_m: kind 0 carries a decoded
// byte, kind 1 ends the field successfully with the byte count, kind 2
// ends it with failure; last_of_run flags the final result of a character.
// The user must write the capacity register through cfg_we_i and
// cfg_data_i only while the block is idle; the block does not enforce it.
// The register resets to 128 bytes. A character is registered on acceptance,
// decoded once the queue has room, and its results queued. One character
// is taken per cycle as long as the four-entry result queue holds two free
// places; a character that yields a byte and a failure costs two output
// beats. Reset empties the queue and closes any open field. When the
// receiver stalls, results wait in the queue, and in_s.ready falls while a
// character waits in the input register and fewer than two places remain.
`default_nettype none
module quoted_hex_string_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  qhd_in_if.sink          in_s,
  qhd_out_if.source       out_m,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_data_i
);
  import qhd_pkg::*;

  logic       space_ok;
  logic [1:0] push_n;
  result_t    res0, res1, head;

  qhd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_s.valid),
    .in_ready_o    (in_s.ready),
    .character_i   (in_s.character),
    .field_start_i (in_s.field_start),
    .text_end_i    (in_s.text_end),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .space_ok_i    (space_ok),
    .push_n_o      (push_n),
    .res0_o        (res0),
    .res1_o        (res1)
  );

  qhd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .res0_i      (res0),
    .res1_i      (res1),
    .space_ok_o  (space_ok),
    .out_valid_o (out_m.valid),
    .out_ready_i (out_m.ready),
    .head_o      (head)
  );

  assign out_m.kind        = head.kind;
  assign out_m.value       = head.value;
  assign out_m.last_of_run = head.last;

endmodule
`default_nettype wire

[design/qhd_core.sv]
// Input register and per-character decode with field state; emits up to two results.
`default_nettype none
module qhd_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      character_i,
  input  wire logic            field_start_i,
  input  wire logic            text_end_i,
  input  wire logic            cfg_we_i,
  input  wire logic [7:0]      cfg_data_i,
  input  wire logic            space_ok_i,
  output logic [1:0]           push_n_o,
  output qhd_pkg::result_t     res0_o,
  output qhd_pkg::result_t     res1_o
);
  import qhd_pkg::*;

  logic       valid_q;
  logic [7:0] char_q;
  logic       start_q;
  logic       end_q;
  logic [7:0] max_bytes_q;

  phase_e     phase_q, phase_d;
  logic [8:0] digit_pos_q, digit_pos_d;
  logic [7:0] byte_count_q, byte_count_d;
  logic [3:0] high_nib_q, high_nib_d;

  logic       proc;
  logic       emit_byte, emit_end;
  kind_e      end_kind;
  logic [7:0] byte_val;
  logic [4:0] hex;
  logic [8:0] pos_next;

  assign proc       = valid_q && space_ok_i;
  assign in_ready_o = !valid_q || proc;
  assign hex        = hex_decode(char_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q  <= character_i;
      start_q <= field_start_i;
      end_q   <= text_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q  <= MAX_BYTES_RESET;
      phase_q      <= PH_IDLE;
      digit_pos_q  <= '0;
      byte_count_q <= '0;
      high_nib_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        max_bytes_q <= cfg_data_i;
      end
      phase_q      <= phase_d;
      digit_pos_q  <= digit_pos_d;
      byte_count_q <= byte_count_d;
      high_nib_q   <= high_nib_d;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    digit_pos_d  = digit_pos_q;
    byte_count_d = byte_count_q;
    high_nib_d   = high_nib_q;
    emit_byte    = 1'b0;
    emit_end     = 1'b0;
    end_kind     = KIND_FAIL;
    byte_val     = {high_nib_q, hex[3:0]};
    pos_next     = (digit_pos_q == DIGIT_POS_MAX) ? digit_pos_q : digit_pos_q + 9'd1;
    if (proc) begin
      if (start_q) begin
        digit_pos_d  = '0;
        byte_count_d = '0;
        high_nib_d   = '0;
        if (end_q || max_bytes_q == 8'd0 || char_q != CHAR_QUOTE) begin
          phase_d  = PH_IDLE;
          emit_end = 1'b1;
        end else begin
          phase_d = PH_OPEN;
        end
      end else if (phase_q == PH_OPEN) begin
        if (char_q == CHAR_QUOTE) begin
          phase_d  = PH_IDLE;
          emit_end = 1'b1;
          end_kind = KIND_DONE;
        end else if (!hex[4]) begin
          phase_d  = PH_IDLE;
          emit_end = 1'b1;
        end else begin
          if (!digit_pos_q[0]) begin
            high_nib_d = hex[3:0];
          end else begin
            emit_byte    = 1'b1;
            byte_count_d = byte_count_q + 8'd1;
          end
          digit_pos_d = pos_next;
          // No closing quote can follow once the capacity is used up.
          if (end_q || pos_next >= {max_bytes_q, 1'b0}) begin
            phase_d  = PH_IDLE;
            emit_end = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    push_n_o = {1'b0, emit_byte} + {1'b0, emit_end};
    res1_o.kind  = end_kind;
    res1_o.value = (end_kind == KIND_DONE) ? byte_count_q : 8'd0;
    res1_o.last  = 1'b1;
    if (emit_byte) begin
      res0_o.kind  = KIND_BYTE;
      res0_o.value = byte_val;
      res0_o.last  = !emit_end;
    end else begin
      res0_o = res1_o;
    end
  end

endmodule
`default_nettype wire

[design/qhd_fifo.sv]
// Four-entry result queue taking up to two results and giving one per cycle while out_ready_i is high.
`default_nettype none
module qhd_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        push_n_i,
  input  wire qhd_pkg::result_t  res0_i,
  input  wire qhd_pkg::result_t  res1_i,
  output logic                   space_ok_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output qhd_pkg::result_t       head_o
);
  import qhd_pkg::*;

  result_t    mem_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;
  logic       pop;

  assign out_valid_o = count_q != 3'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign head_o      = mem_q[rd_ptr_q];
  // Room for the worst case of two results from the next character.
  assign space_ok_o  = count_q <= 3'd2;

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n_i;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      count_q  <= count_q + {1'b0, push_n_i} - {2'b0, pop};
    end
  end

endmodule
`default_nettype wire

[design/qhd_checker.sv]
// Port-level checks of the quoted hex string decoder and their bind.
`default_nettype none
`include "assert_macros.svh"
module qhd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [1:0] out_kind_i,
  input wire logic [7:0] out_value_i,
  input wire logic       out_last_i
);
  import qhd_pkg::*;

  `QHD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) && $stable(out_value_i) && $stable(out_last_i), "stalled result beat changed")
  `QHD_ASSERT(a_kind_legal, out_valid_i |-> out_kind_i == KIND_BYTE || out_kind_i == KIND_DONE || out_kind_i == KIND_FAIL, "illegal result kind")
  `QHD_ASSERT(a_fail_zero, out_valid_i && out_kind_i == KIND_FAIL |-> out_value_i == 8'd0, "failure beat carries a nonzero value")
  `QHD_ASSERT(a_end_last, out_valid_i && out_kind_i != KIND_BYTE |-> out_last_i, "field end not flagged as last of run")
  `QHD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_i, "result offered straight after reset")

endmodule

bind quoted_hex_string_decoder qhd_checker u_qhd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_m.valid),
  .out_ready_i (out_m.ready),
  .out_kind_i  (out_m.kind),
  .out_value_i (out_m.value),
  .out_last_i  (out_m.last_of_run)
);
`default_nettype wire

[tb/tb_quoted_hex_string_decoder.sv]
// Testbench for the quoted hex string decoder: directed and random fields, checked beat by beat.
module tb_quoted_hex_string_decoder;
  import qhd_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  typedef enum {
    FE_QUOTE,
    FE_QUOTE_LAST,
    FE_TEXT_END,
    FE_BAD,
    FE_OPEN
  } field_end_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  logic [7:0] cfg_data;

  qhd_in_if  in_if();
  qhd_out_if out_if();

  quoted_hex_string_decoder u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_s      (in_if),
    .out_m     (out_if),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data)
  );

  // Mirror of the decoder state.
  logic [7:0] cap_bytes;
  bit         field_open;
  logic [8:0] digits_taken;
  logic [7:0] bytes_done;
  logic [3:0] pending_nibble;

  result_t     awaited_results[$];
  result_t     want;
  int unsigned errors;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  bit          steady_flow;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bit 4 set marks a hex digit; bits 3:0 carry its value.
  function automatic logic [4:0] digit_of(input logic [7:0] ch);
    logic [7:0] t;
    t = 8'd0;
    if (ch >= CHAR_0 && ch <= CHAR_9) begin
      t = ch - CHAR_0;
      return {1'b1, t[3:0]};
    end
    if (ch >= CHAR_UA && ch <= CHAR_UF) begin
      t = ch - CHAR_UA + 8'd10;
      return {1'b1, t[3:0]};
    end
    if (ch >= CHAR_LA && ch <= CHAR_LF) begin
      t = ch - CHAR_LA + 8'd10;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  // Works out the results of one accepted character; returns 0 if it is ignored.
  function automatic bit decode_char(input logic [7:0] ch, input logic start,
                                     input logic last);
    logic [4:0] nib;
    logic [7:0] byte_val;
    bit         give_byte;
    bit         give_done;
    bit         give_fail;
    result_t    r;
    give_byte = 1'b0;
    give_done = 1'b0;
    give_fail = 1'b0;
    byte_val  = 8'd0;
    if (start) begin
      field_open     = 1'b0;
      digits_taken   = 9'd0;
      bytes_done     = 8'd0;
      pending_nibble = 4'd0;
      if (last || cap_bytes == 8'd0 || ch != CHAR_QUOTE) begin
        give_fail = 1'b1;
      end else begin
        field_open = 1'b1;
      end
    end else if (!field_open) begin
      return 1'b0;
    end else if (ch == CHAR_QUOTE) begin
      field_open = 1'b0;
      give_done  = 1'b1;
    end else begin
      nib = digit_of(ch);
      if (!nib[4]) begin
        field_open = 1'b0;
        give_fail  = 1'b1;
      end else begin
        if (!digits_taken[0]) begin
          pending_nibble = nib[3:0];
        end else begin
          give_byte  = 1'b1;
          byte_val   = {pending_nibble, nib[3:0]};
          bytes_done = bytes_done + 8'd1;
        end
        if (digits_taken != DIGIT_POS_MAX) digits_taken = digits_taken + 9'd1;
        // Once the buffer is full no closing quote can be taken any more.
        if (last || digits_taken >= {cap_bytes, 1'b0}) begin
          field_open = 1'b0;
          give_fail  = 1'b1;
        end
      end
    end
    if (give_byte) begin
      r.kind  = KIND_BYTE;
      r.value = byte_val;
      r.last  = !give_fail;
      awaited_results.push_back(r);
    end
    if (give_done) begin
      r.kind  = KIND_DONE;
      r.value = bytes_done;
      r.last  = 1'b1;
      awaited_results.push_back(r);
    end
    if (give_fail) begin
      r.kind  = KIND_FAIL;
      r.value = 8'd0;
      r.last  = 1'b1;
      awaited_results.push_back(r);
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return CHAR_0 + {4'd0, v};
    return (upper ? CHAR_UA : CHAR_LA) + {4'd0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] random_digit();
    return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] ch;
    logic [4:0] nib;
    // Half the time pick a neighbour of a digit range.
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 5))
        0: ch = CHAR_0 - 8'd1;
        1: ch = CHAR_9 + 8'd1;
        2: ch = CHAR_UA - 8'd1;
        3: ch = CHAR_UF + 8'd1;
        4: ch = CHAR_LA - 8'd1;
        default: ch = CHAR_LF + 8'd1;
      endcase
      return ch;
    end
    do begin
      ch  = 8'($urandom_range(0, 255));
      nib = digit_of(ch);
    end while (nib[4] || ch == CHAR_QUOTE);
    return ch;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_char(input logic [7:0] ch, input logic start, input logic last);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.character   <= ch;
    in_if.field_start <= start;
    in_if.text_end    <= last;
    do @(posedge clk_i); while (!in_if.ready);
    if (decode_char(ch, start, last)) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input bit end_on_last);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == 0, end_on_last && i == s.len() - 1);
    end
  endtask

  task automatic send_field(input int unsigned n_digits, input field_end_e ending);
    int unsigned n;
    n = (ending == FE_TEXT_END && n_digits == 0) ? 1 : n_digits;
    send_char(CHAR_QUOTE, 1'b1, 1'b0);
    for (int unsigned i = 0; i < n; i++) begin
      send_char(random_digit(), 1'b0, ending == FE_TEXT_END && i == n - 1);
    end
    case (ending)
      FE_QUOTE:      send_char(CHAR_QUOTE, 1'b0, 1'b0);
      FE_QUOTE_LAST: send_char(CHAR_QUOTE, 1'b0, 1'b1);
      FE_BAD:        send_char(bad_char(), 1'b0, 1'($urandom_range(0, 1)));
      default: ;
    endcase
  endtask

  // Stops driving input, lets every awaited result arrive, then waits for the bench to settle.
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [7:0] cap);
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    cap_bytes  = cap;
  endtask

  task automatic test_directed_fields();
    send_char("x", 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b1);
    send_char(8'h00, 1'b1, 1'b0);
    send_char(CHAR_QUOTE, 1'b1, 1'b1);
    send_text("\"09AFaf\"", 1'b0);
    send_text("\"1\"", 1'b1);
    send_text("\"4g", 1'b0);
    send_text("\"12", 1'b1);
    // A new field abandons the open one silently.
    send_text("\"7", 1'b0);
    send_text("\"56\"", 1'b0);
    wait_drain();
  endtask

  task automatic test_capacity_limits();
    write_capacity(8'd0);
    send_text("\"12\"", 1'b0);
    wait_drain();
    write_capacity(8'd1);
    send_text("\"ABC\"", 1'b0);
    send_text("\"A\"", 1'b0);
    wait_drain();
    write_capacity(8'd255);
    send_field(510, FE_QUOTE);
    wait_drain();
    // Capacity lowered while a field is open.
    write_capacity(8'd4);
    send_text("\"1234", 1'b0);
    wait_drain();
    write_capacity(8'd1);
    send_char("5", 1'b0, 1'b0);
    wait_drain();
    write_capacity(8'd8);
    send_text("\"123", 1'b0);
    wait_drain();
    write_capacity(8'd1);
    send_char("4", 1'b0, 1'b0);
    wait_drain();
  endtask

  task automatic run_traffic(input int unsigned n_items);
    int unsigned target;
    int unsigned pick;
    int unsigned n_digits;
    int unsigned span;
    field_end_e  ending;
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        span = 2 * cap_bytes + 2;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: n_digits = $urandom_range(0, 8);
          6, 7, 8:          n_digits = $urandom_range(0, span > 40 ? 40 : span);
          default: begin
            if (cap_bytes != 8'd0 && cap_bytes <= 8'd20) begin
              n_digits = 2 * cap_bytes - 1 + $urandom_range(0, 2);
            end else begin
              n_digits = $urandom_range(0, 4);
            end
          end
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: ending = FE_QUOTE;
          6:                ending = FE_QUOTE_LAST;
          7:                ending = FE_TEXT_END;
          8:                ending = FE_BAD;
          default:          ending = FE_OPEN;
        endcase
        send_field(n_digits, ending);
      end else if (pick < 92) begin
        send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                  $urandom_range(0, 7) == 0);
      end else if (pick < 97) begin
        send_char($urandom_range(0, 3) == 0 ? CHAR_QUOTE : bad_char(), 1'b1,
                  1'($urandom_range(0, 1)));
      end else begin
        wait_drain();
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [7:0] caps[7];
    caps = '{8'd1, 8'd2, 8'd3, 8'd255, 8'd0, 8'd4, 8'd128};
    caps[5] = 8'($urandom_range(4, 20));
    caps[6] = 8'($urandom_range(0, 255));
    foreach (caps[i]) begin
      wait_drain();
      write_capacity(caps[i]);
      run_traffic(caps[i] == 8'd0 ? 40 : 110);
    end
  endtask

  task automatic test_back_to_back();
    wait_drain();
    write_capacity(8'($urandom_range(1, 12)));
    steady_flow = 1'b1;
    run_traffic(100);
    wait_drain();
    steady_flow = 1'b0;
  endtask

  // Result sink: draws a stall before each beat, except in steady flow.
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      stall = steady_flow ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0d value %h last %b",
                 $time, out_if.kind, out_if.value, out_if.last_of_run);
      end else begin
        want = awaited_results.pop_front();
        if (out_if.kind !== want.kind) begin
          errors++;
          $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind,
                   out_if.kind);
        end
        if (out_if.value !== want.value) begin
          errors++;
          $display("%0t: value mismatch, expected %h, got %h", $time, want.value,
                   out_if.value);
        end
        if (out_if.last_of_run !== want.last) begin
          errors++;
          $display("%0t: last_of_run mismatch, expected %b, got %b", $time, want.last,
                   out_if.last_of_run);
        end
      end
    end
  end

  // Ends the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_data          = 8'd0;
    in_if.valid       = 1'b0;
    in_if.character   = 8'd0;
    in_if.field_start = 1'b0;
    in_if.text_end    = 1'b0;
    errors            = 0;
    items_sent        = 0;
    quiet_cycles      = 0;
    steady_flow       = 1'b0;
    cap_bytes         = MAX_BYTES_RESET;
    field_open        = 1'b0;
    digits_taken      = 9'd0;
    bytes_done        = 8'd0;
    pending_nibble    = 4'd0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_fields();
    test_capacity_limits();
    test_random_traffic();
    test_back_to_back();

    wait_drain();
    repeat (10) @(negedge clk_i);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/qhd_pkg.sv
design/qhd_ifs.sv
design/qhd_core.sv
design/qhd_fifo.sv
design/quoted_hex_string_decoder.sv
design/qhd_checker.sv
tb/tb_quoted_hex_string_decoder.sv
